// ===== hw/rtl/hti_pkg.sv =====
// Package with the parse phases, character codes and character classifier.
`default_nettype none

package hti_pkg;

  // Width of the result value port.
  localparam int RESULT_WIDTH = 32;
  // Default width of the accumulator.
  localparam int VALUE_WIDTH_DEF = 32;

  // ASCII codes the parser looks for.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  // Value of the first letter digit.
  localparam logic [7:0] LETTER_BASE = 8'd10;

  // Character classes beyond the sixteen digit values.
  localparam logic [4:0] CLS_SEP = 5'd16;
  localparam logic [4:0] CLS_BAD = 5'd17;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_ZERO  = 3'd2,
    PH_DIGIT = 3'd3,
    PH_ERR   = 3'd4
  } phase_t;

  // Returns the digit value 0 to 15, CLS_SEP for a separator, CLS_BAD otherwise.
  function automatic logic [4:0] char_class(input logic [7:0] c);
    logic [7:0] d;
    d = {3'b000, CLS_BAD};
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + LETTER_BASE;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + LETTER_BASE;
    end else if (c == CH_USCORE || c == CH_SPACE) begin
      d = {3'b000, CLS_SEP};
    end
    return d[4:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hex_text_to_integer.sv =====
// Streaming parser that turns signed hexadecimal text into an integer.
// The block takes one character word per cycle and updates its parse state
// in a single registered step, so a new character word can be accepted in every cycle.
// A word with end_of_string set produces one result word in the output register
// in the next cycle; while that result waits, further character words are
// still taken, and only another terminator waits for the output to drain.
// Leading spaces are skipped, one '+' or '-' and a "0x"/"0X" prefix are
// accepted, '_' and ' ' act as separators, and any other character makes the
// result -1 with parse_error set. The accumulator is VALUE_WIDTH bits wide
// and wraps; its signed value is sign-extended or truncated to 32 bits.
`default_nettype none

module hex_text_to_integer
  import hti_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_character,
  input  wire logic                           in_end_of_string,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [RESULT_WIDTH-1:0]      out_result_value,
  output logic                                out_parse_error
);

  // Parse state.
  phase_t                   phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]   acc_r, acc_nxt;
  logic                     neg_r, neg_nxt;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  logic [RESULT_WIDTH-1:0]  res_value_r, res_value_nxt;
  logic                     res_error_r, res_error_nxt;

  logic                     in_fire;
  logic [4:0]               cls;
  logic [VALUE_WIDTH-1:0]   signed_val;
  logic [RESULT_WIDTH-1:0]  res_ext;

  // A terminator needs a free output register; characters are always taken.
  assign in_ready = !in_end_of_string || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cls      = char_class(in_character);

  // Apply the sign in the accumulator width, then fit to the result width.
  assign signed_val = neg_r ? (~acc_r + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : acc_r;

  generate
    if (VALUE_WIDTH >= RESULT_WIDTH) begin : g_trunc
      assign res_ext = signed_val[RESULT_WIDTH-1:0];
    end else begin : g_sext
      assign res_ext = {{(RESULT_WIDTH-VALUE_WIDTH){signed_val[VALUE_WIDTH-1]}}, signed_val};
    end
  endgenerate

  // Next parse state and result for the accepted word.
  always_comb begin
    logic take_digit;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_value_nxt = res_value_r;
    res_error_nxt = res_error_r;
    take_digit    = 1'b0;

    if (in_fire) begin
      if (in_end_of_string) begin
        out_valid_nxt = 1'b1;
        if (phase_r == PH_ERR) begin
          res_value_nxt = '1;
          res_error_nxt = 1'b1;
        end else begin
          res_value_nxt = res_ext;
          res_error_nxt = 1'b0;
        end
        phase_nxt = PH_LEAD;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
      end else begin
        unique case (phase_r)
          PH_LEAD: begin
            priority if (in_character == CH_SPACE) begin
              phase_nxt = PH_LEAD;
            end else if (in_character == CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_SIGN;
            end else if (in_character == CH_PLUS) begin
              phase_nxt = PH_SIGN;
            end else if (in_character == CH_0) begin
              phase_nxt = PH_ZERO;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_SIGN: begin
            if (in_character == CH_0) begin
              phase_nxt = PH_ZERO;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_ZERO: begin
            if (in_character == CH_LX || in_character == CH_UX) begin
              phase_nxt = PH_DIGIT;
            end else begin
              take_digit = 1'b1;
            end
          end
          PH_DIGIT: begin
            take_digit = 1'b1;
          end
          default: begin
            phase_nxt = PH_ERR;
          end
        endcase

        // Digits shift in, separators pass, anything else is an error.
        if (take_digit) begin
          priority if (cls == CLS_BAD) begin
            phase_nxt = PH_ERR;
          end else if (cls == CLS_SEP) begin
            phase_nxt = PH_DIGIT;
          end else begin
            phase_nxt = PH_DIGIT;
            acc_nxt   = {acc_r[VALUE_WIDTH-5:0], cls[3:0]};
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_error_r <= res_error_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_value_r;
  assign out_parse_error  = res_error_r;

  // A terminator leaves the parser in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_string |=> phase_r == PH_LEAD && acc_r == '0 && !neg_r)
    else $error("parse state not cleared after terminator");

  // A new result appears only after a terminator word.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_end_of_string))
    else $error("result without terminator");

  // An error result always carries the value -1.
  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_error_r |-> res_value_r == '1)
    else $error("error result is not -1");

  // The error phase holds until the terminator.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR && !(in_fire && in_end_of_string) |=> phase_r == PH_ERR)
    else $error("error phase left before terminator");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the hex text parser: directed and random text checked against a parser model.
module testbench
  import hti_pkg::*;
();

  // One parsed value as the block reports it.
  typedef struct {
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           err;
  } parsed_value_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_character = 8'h00;
  logic                           in_end_of_string = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [RESULT_WIDTH-1:0] out_result_value;
  logic                           out_parse_error;

  // Traffic shaping, shared with the receiver process.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  // Bookkeeping for the summary and the verdict.
  int fail_count = 0;
  int words_sent = 0;
  int values_checked = 0;
  int invalid_texts = 0;

  // Parser model state.
  phase_t                    model_phase = PH_LEAD;
  logic [VALUE_WIDTH_DEF-1:0] model_acc = '0;
  logic                      model_negative = 1'b0;

  parsed_value_t pending_values[$];
  logic [7:0]    text_buf[$];

  hex_text_to_integer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_parse_error  (out_parse_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare every result word with the oldest predicted value.
  always @(posedge clk) begin : check_values
    parsed_value_t want;
    if (rst_n && out_valid && out_ready) begin
      values_checked++;
      if (pending_values.size() == 0) begin
        $error("unexpected result word: result_value %0d, parse_error %0b",
               out_result_value, out_parse_error);
        fail_count++;
      end else begin
        want = pending_values.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, out_result_value);
          fail_count++;
        end
        if (out_parse_error !== want.err) begin
          $error("parse_error: expected %0b, got %0b", want.err, out_parse_error);
          fail_count++;
        end
      end
    end
  end

  // Digit value 0 to 15, CLS_SEP for a separator, CLS_BAD for anything else.
  function automatic logic [4:0] hex_digit_code(input logic [7:0] c);
    logic [7:0] code;
    if (c >= CH_0 && c <= CH_9) begin
      code = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      code = c - CH_LA + LETTER_BASE;
    end else if (c >= CH_UA && c <= CH_UF) begin
      code = c - CH_UA + LETTER_BASE;
    end else if (c == CH_USCORE || c == CH_SPACE) begin
      code = {3'b000, CLS_SEP};
    end else begin
      code = {3'b000, CLS_BAD};
    end
    return code[4:0];
  endfunction

  // A character in the digit part: shift a digit in, skip a separator, or fail.
  task automatic shift_in_digit(input logic [7:0] c);
    logic [4:0] code;
    code = hex_digit_code(c);
    model_phase = PH_DIGIT;
    if (code < CLS_SEP) begin
      model_acc = {model_acc[VALUE_WIDTH_DEF-5:0], code[3:0]};
    end else if (code == CLS_BAD) begin
      model_phase = PH_ERR;
    end
  endtask

  // Advance the parser model by one accepted word; a terminator yields a value.
  task automatic step_parser(input logic [7:0] c, input logic eos);
    parsed_value_t want;
    if (eos) begin
      if (model_phase >= PH_ERR) begin
        want.value = -1;
        want.err = 1'b1;
        invalid_texts++;
      end else begin
        want.value = model_negative ? -model_acc : model_acc;
        want.err = 1'b0;
      end
      pending_values.push_back(want);
      model_phase = PH_LEAD;
      model_acc = '0;
      model_negative = 1'b0;
    end else begin
      case (model_phase)
        PH_LEAD: begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            model_negative = (c == CH_MINUS);
            model_phase = PH_SIGN;
          end else if (c == CH_0) begin
            model_phase = PH_ZERO;
          end else if (c != CH_SPACE) begin
            shift_in_digit(c);
          end
        end
        PH_SIGN: begin
          if (c == CH_0) model_phase = PH_ZERO;
          else shift_in_digit(c);
        end
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) model_phase = PH_DIGIT;
          else shift_in_digit(c);
        end
        PH_DIGIT: shift_in_digit(c);
        default: model_phase = PH_ERR;
      endcase
    end
  endtask

  // Offer one word, idling first at random, and hold it until it is taken.
  task automatic send_word(input logic [7:0] c, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= c;
    in_end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    step_parser(c, eos);
  endtask

  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] random_hex_digit();
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 21);
    if (k < 10) c = CH_0 + 8'(k);
    else if (k < 16) c = CH_LA + 8'(k - 10);
    else c = CH_UA + 8'(k - 16);
    return c;
  endfunction

  // Terminator word; its character field carries junk the block must ignore.
  task automatic end_text();
    send_word(random_byte(), 1'b1);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    end_text();
  endtask

  task automatic send_text_buf();
    foreach (text_buf[i]) send_word(text_buf[i], 1'b0);
    end_text();
  endtask

  // Stop offering and wait until every predicted value has come out.
  task automatic wait_for_values();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed text: spaces, sign, prefix, digits with separators.
  task automatic build_random_text();
    int digits;
    text_buf.delete();
    repeat ($urandom_range(0, 2)) text_buf.push_back(CH_SPACE);
    case ($urandom_range(0, 3))
      0: text_buf.push_back(CH_MINUS);
      1: text_buf.push_back(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      text_buf.push_back(CH_0);
      text_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    digits = $urandom_range(0, 12);
    repeat (digits) begin
      if ($urandom_range(0, 6) == 0) begin
        text_buf.push_back($urandom_range(0, 1) ? CH_USCORE : CH_SPACE);
      end
      text_buf.push_back(random_hex_digit());
    end
    // About one text in five gets broken by a stray byte, a stray x or a late sign.
    if ($urandom_range(0, 4) == 0) begin
      logic [7:0] stray;
      case ($urandom_range(0, 3))
        0: stray = CH_LX;
        1: stray = CH_MINUS;
        default: stray = random_byte();
      endcase
      if (text_buf.size() == 0) text_buf.push_back(stray);
      else text_buf[$urandom_range(0, text_buf.size() - 1)] = stray;
    end
  endtask

  // Empty text, a lone sign and a lone prefix all give zero.
  task automatic test_empty_and_bare_text();
    send_string("");
    send_string("-");
    send_string("0X");
  endtask

  // A space after the sign is a separator, so the following x is no prefix.
  task automatic test_misplaced_prefix();
    send_string("+ 0x");
  endtask

  // NUL is invalid and the error sticks through the all-ones byte.
  task automatic test_invalid_characters();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    end_text();
  endtask

  // Ten digits shift the top ones out, then the value is negated.
  task automatic test_wide_value();
    send_string(" -fA_23456789");
  endtask

  task automatic test_random_text(input int word_count, input int idle_pct,
                                  input int stall_pct);
    int start;
    start = words_sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (words_sent - start < word_count) begin
      build_random_text();
      send_text_buf();
    end
    wait_for_values();
  endtask

  // Receiver holds off for a long stretch while texts keep coming.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 60;
    repeat (6) begin
      build_random_text();
      send_text_buf();
    end
    wait_for_values();
  endtask

  // Sender pauses until the output is empty, then resumes.
  task automatic test_pause_until_drained();
    send_string("-0x1");
    wait_for_values();
    send_string("7_F");
    wait_for_values();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_bare_text();
    test_misplaced_prefix();
    test_invalid_characters();
    test_wide_value();
    wait_for_values();
    test_random_text(150, 9, 82);
    test_output_hold();
    test_random_text(150, 82, 9);
    test_pause_until_drained();
    test_random_text(150, 0, 0);
    wait_for_values();
    repeat (8) @(posedge clk);
    $display("summary: %0d character words sent, %0d parsed values checked",
             words_sent, values_checked);
    $display("summary: %0d texts ended in a parse error", invalid_texts);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hti_pkg.sv
hw/rtl/hex_text_to_integer.sv
tb/testbench.sv
